>>> rtl/core/esd_pkg.sv
// Shared types and constants for the escape sequence decoder.
`default_nettype none
package esd_pkg;

  // Default size of the ban list
  localparam int BAN_ENTRIES_DEF = 8;

  // Configuration register indexes
  localparam logic [1:0] CFG_BAN_ENABLE = 2'd0;
  localparam logic [1:0] CFG_BAN_BYTES  = 2'd1;
  localparam logic [1:0] CFG_BAN_COUNT  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BANNED  = 2'd2;

  // Characters the decoder recognizes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_D   = 8'h64;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;
  localparam logic [7:0] CTRL_BASE = 8'h40;
  localparam logic [7:0] CTRL_MASK = 8'h7F;
  localparam logic [9:0] BYTE_MAX  = 10'd255;

  // Decoder modes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_CARET,
    MODE_DEC,
    MODE_HEX,
    MODE_OCT,
    MODE_DROP
  } mode_t;

  // Outcome of one character before ban check and string-end handling
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_MORE,
    ACT_EMIT,
    ACT_FAIL
  } act_t;

  // Decoder state
  typedef struct packed {
    mode_t      mode;
    logic [1:0] digit_idx;
    logic [9:0] acc;
  } dec_state_t;

  // One result word
  typedef struct packed {
    logic [7:0] byte_val;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/core/escape_sequence_decoder_unit.sv
// Top level of the backslash escape sequence decoder.
`default_nettype none
// Decodes a string arriving one character per word on the slave stream
// (tlast marks the final character) into bytes on the master stream. Plain
// characters pass through; backslash escapes (letters, \^X, \d, \x, octal)
// become one byte each. tuser carries the status: OK, invalid escape, or
// banned byte; any error word has tlast set, and the rest of that string is
// dropped, so the consumer should discard the bytes of that string it already
// took. One character is accepted every cycle while the output buffer has
// room, and each result is registered into it. A two-entry output buffer
// keeps input flowing while one result waits; tready drops only when both
// entries are full. Configuration writes are accepted at any time and take
// effect for the next character; index 3 is ignored.
module escape_sequence_decoder_unit #(
  parameter int BAN_ENTRIES = esd_pkg::BAN_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Slave stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_in
  input  wire logic        s_tlast,   // last_in
  // Master stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] byte_out
  output logic [1:0]       m_tuser,   // [1:0] status
  output logic             m_tlast,   // last_out
  // Configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import esd_pkg::*;

  localparam int BAN_W = BAN_ENTRIES * 8;

  logic             ban_enable;
  logic [BAN_W-1:0] ban_bytes;
  logic [3:0]       ban_count;
  dec_state_t       state;
  dec_state_t       state_next;
  logic             res_valid;
  result_t          res;
  logic             accept;
  logic             has_room;
  result_t          out_word;

  assign cfg_ready = 1'b1;
  assign s_tready  = has_room;
  assign accept    = s_tvalid && has_room;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ban_enable <= 1'b0;
      ban_bytes  <= '0;
      ban_count  <= 4'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BAN_ENABLE: ban_enable <= cfg_data[0];
        CFG_BAN_BYTES:  ban_bytes  <= cfg_data[BAN_W-1:0];
        CFG_BAN_COUNT:  ban_count  <= cfg_data[3:0];
        default:        ban_enable <= ban_enable;
      endcase
    end
  end

  esd_decode #(
    .BAN_ENTRIES(BAN_ENTRIES)
  ) u_decode (
    .cur       (state),
    .char_in   (s_tdata),
    .last_in   (s_tlast),
    .ban_enable(ban_enable),
    .ban_bytes (ban_bytes),
    .ban_count (ban_count),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  // Decoder state advances on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: MODE_IDLE, digit_idx: 2'd0, acc: 10'd0};
    end else if (accept) begin
      state <= state_next;
    end
  end

  esd_out_buf u_out (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && res_valid),
    .wr_data (res),
    .has_room(has_room),
    .rd_valid(m_tvalid),
    .rd_ready(m_tready),
    .rd_data (out_word)
  );

  assign m_tdata = out_word.byte_val;
  assign m_tuser = out_word.status;
  assign m_tlast = out_word.last;

  // Error words always close the string and carry no byte
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tlast && (m_tdata == 8'd0)))
    else $error("error word without tlast or with nonzero byte");

  // Back-pressure only while a result is pending
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output buffer");

  // An error before the end of a string drops the rest of it
  a_err_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && (res.status != ST_OK) && !s_tlast)
      |=> (state.mode == MODE_DROP))
    else $error("decoder not dropping after mid-string error");

  // A string end always returns the decoder to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (state.mode == MODE_IDLE) && (state.acc == 10'd0))
    else $error("decoder not idle after end of string");

endmodule
`default_nettype wire

>>> rtl/core/esd_ban_match.sv
// Ban list comparator: flags a byte that matches a valid ban entry.
`default_nettype none
module esd_ban_match #(
  parameter int BAN_ENTRIES = esd_pkg::BAN_ENTRIES_DEF
) (
  input  wire logic [7:0]               byte_val,
  input  wire logic                     ban_enable,
  input  wire logic [BAN_ENTRIES*8-1:0] ban_bytes,
  input  wire logic [3:0]               ban_count,
  output logic                          hit
);
  import esd_pkg::*;

  logic [BAN_ENTRIES-1:0] match;

  // Compare each entry; entry i is valid when i is below the count, so a
  // count above the list size simply enables every entry
  for (genvar i = 0; i < BAN_ENTRIES; i++) begin : g_entry
    assign match[i] = (4'(i) < ban_count) && (ban_bytes[8*i +: 8] == byte_val);
  end

  assign hit = ban_enable && (|match);

endmodule
`default_nettype wire

>>> rtl/core/esd_decode.sv
// Single-character escape decoder: next state and optional result.
`default_nettype none
module esd_decode #(
  parameter int BAN_ENTRIES = esd_pkg::BAN_ENTRIES_DEF
) (
  input  wire esd_pkg::dec_state_t      cur,
  input  wire logic [7:0]               char_in,
  input  wire logic                     last_in,
  input  wire logic                     ban_enable,
  input  wire logic [BAN_ENTRIES*8-1:0] ban_bytes,
  input  wire logic [3:0]               ban_count,
  output esd_pkg::dec_state_t           nxt,
  output logic                          res_valid,
  output esd_pkg::result_t              res
);
  import esd_pkg::*;

  logic [7:0] lc;
  logic [7:0] uc;
  logic [7:0] dig;
  logic       is_dec;
  logic       is_oct;
  logic       is_hex;
  logic [3:0] hex_val;
  logic [1:0] idx_inc;
  logic [9:0] acc_dec;
  logic [9:0] acc_hex;
  logic [9:0] acc_oct;
  act_t       act;
  logic [7:0] emit_val;
  dec_state_t step;
  logic       banned;
  logic [1:0] st;

  // Character classes
  always_comb begin
    lc      = ((char_in >= CH_UC_A) && (char_in <= CH_UC_Z)) ? char_in + CASE_GAP : char_in;
    uc      = ((char_in >= CH_LC_A) && (char_in <= CH_LC_Z)) ? char_in - CASE_GAP : char_in;
    dig     = char_in - CH_ZERO;
    is_dec  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    is_oct  = (char_in >= CH_ZERO) && (char_in <= CH_SEVEN);
    hex_val = dig[3:0];
    is_hex  = is_dec;
    if ((uc >= CH_UC_A) && (uc <= CH_UC_F)) begin
      is_hex  = 1'b1;
      hex_val = 4'(uc - CH_UC_A + 8'd10);
    end
  end

  // Digit accumulation, kept to ten bits
  assign idx_inc = cur.digit_idx + 2'd1;
  assign acc_dec = (cur.acc << 3) + (cur.acc << 1) + {6'd0, dig[3:0]};
  assign acc_hex = (cur.acc << 4) + {6'd0, hex_val};
  assign acc_oct = (cur.acc << 3) + {7'd0, dig[2:0]};

  // Classify the character against the current mode
  always_comb begin
    step     = cur;
    act      = ACT_NONE;
    emit_val = char_in;
    unique case (cur.mode)
      MODE_IDLE: begin
        if (char_in == CH_BSLASH) begin
          step.mode = MODE_ESC;
          act       = ACT_MORE;
        end else begin
          act = ACT_EMIT;
        end
      end
      MODE_ESC: begin
        act = ACT_EMIT;
        unique case (lc)
          CH_BSLASH: emit_val = 8'h5C;
          CH_LC_A:   emit_val = 8'h07;
          CH_LC_B:   emit_val = 8'h08;
          CH_LC_T:   emit_val = 8'h09;
          CH_LC_N:   emit_val = 8'h0A;
          CH_LC_V:   emit_val = 8'h0B;
          CH_LC_F:   emit_val = 8'h0C;
          CH_LC_R:   emit_val = 8'h0D;
          CH_LC_E:   emit_val = 8'h1B;
          CH_CARET: begin
            step.mode = MODE_CARET;
            act       = ACT_MORE;
          end
          CH_LC_D: begin
            step.mode      = MODE_DEC;
            step.digit_idx = 2'd0;
            step.acc       = 10'd0;
            act            = ACT_MORE;
          end
          CH_LC_X: begin
            step.mode      = MODE_HEX;
            step.digit_idx = 2'd0;
            step.acc       = 10'd0;
            act            = ACT_MORE;
          end
          default: begin
            if (is_oct) begin
              step.mode      = MODE_OCT;
              step.digit_idx = 2'd1;
              step.acc       = {7'd0, dig[2:0]};
              act            = ACT_MORE;
            end else begin
              act = ACT_FAIL;
            end
          end
        endcase
      end
      MODE_CARET: begin
        if ((uc < CH_QUEST) || (uc > CH_UNDER)) begin
          act = ACT_FAIL;
        end else begin
          act      = ACT_EMIT;
          emit_val = (uc - CTRL_BASE) & CTRL_MASK;
        end
      end
      MODE_DEC: begin
        step.acc       = acc_dec;
        step.digit_idx = idx_inc;
        emit_val       = acc_dec[7:0];
        if (!is_dec) act = ACT_FAIL;
        else if (idx_inc != 2'd3) act = ACT_MORE;
        else if (acc_dec > BYTE_MAX) act = ACT_FAIL;
        else act = ACT_EMIT;
      end
      MODE_HEX: begin
        step.acc       = acc_hex;
        step.digit_idx = idx_inc;
        emit_val       = acc_hex[7:0];
        if (!is_hex) act = ACT_FAIL;
        else if (idx_inc < 2'd2) act = ACT_MORE;
        else act = ACT_EMIT;
      end
      MODE_OCT: begin
        step.acc       = acc_oct;
        step.digit_idx = idx_inc;
        emit_val       = acc_oct[7:0];
        if (!is_oct) act = ACT_FAIL;
        else if (idx_inc != 2'd3) act = ACT_MORE;
        else if (acc_oct > BYTE_MAX) act = ACT_FAIL;
        else act = ACT_EMIT;
      end
      MODE_DROP: begin
        act = ACT_NONE;
      end
      default: begin
        act = ACT_NONE;
      end
    endcase
  end

  esd_ban_match #(
    .BAN_ENTRIES(BAN_ENTRIES)
  ) u_ban (
    .byte_val  (emit_val),
    .ban_enable(ban_enable),
    .ban_bytes (ban_bytes),
    .ban_count (ban_count),
    .hit       (banned)
  );

  // Resolve the outcome: ban check, string end, error recovery
  always_comb begin
    nxt       = step;
    res_valid = 1'b0;
    st        = ST_OK;
    unique case (act)
      ACT_NONE: begin
        if (last_in) nxt = '{mode: MODE_IDLE, digit_idx: 2'd0, acc: 10'd0};
      end
      ACT_MORE: begin
        if (last_in) begin
          res_valid = 1'b1;
          st        = ST_INVALID;
        end
      end
      ACT_EMIT: begin
        res_valid = 1'b1;
        st        = banned ? ST_BANNED : ST_OK;
      end
      ACT_FAIL: begin
        res_valid = 1'b1;
        st        = ST_INVALID;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    res.byte_val = (st == ST_OK) ? emit_val : 8'd0;
    res.status   = st;
    res.last     = last_in || (st != ST_OK);
    // Any result closes the escape; an error mid-string drops the rest
    if (res_valid) begin
      nxt.mode      = ((st != ST_OK) && !last_in) ? MODE_DROP : MODE_IDLE;
      nxt.digit_idx = 2'd0;
      nxt.acc       = 10'd0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/esd_out_buf.sv
// Two-entry result buffer between the decoder and the output stream.
`default_nettype none
module esd_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire esd_pkg::result_t wr_data,
  output logic                  has_room,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output esd_pkg::result_t      rd_data
);
  import esd_pkg::*;

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       rd_en;

  assign has_room = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = entry[rd_ptr];
  assign rd_en    = rd_valid && rd_ready;

  // Store an incoming word
  always_ff @(posedge clk) begin
    if (wr_en) entry[wr_ptr] <= wr_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the escape sequence decoder unit.
`timescale 1ns / 100ps

import esd_pkg::*;

// Track decoder state and config; hold the decoded words still to come
class decode_scoreboard;
  mode_t       mode;
  logic [1:0]  digit_cnt;
  logic [9:0]  acc;
  bit          ban_en;
  logic [63:0] ban_list;
  logic [3:0]  ban_cnt;
  result_t     pending_bytes[$];
  int          errors;

  function new();
    mode = MODE_IDLE;
    digit_cnt = '0;
    acc = '0;
    ban_en = 1'b0;
    ban_list = '0;
    ban_cnt = '0;
    errors = 0;
  endfunction

  function int pending();
    return pending_bytes.size();
  endfunction

  function void set_reg(logic [1:0] idx, logic [63:0] val);
    case (idx)
      CFG_BAN_ENABLE: ban_en = val[0];
      CFG_BAN_BYTES:  ban_list = val;
      CFG_BAN_COUNT:  ban_cnt = val[3:0];
      default: ;
    endcase
  endfunction

  // Queue one result; any error closes the string and drops its tail
  function void close_word(logic [1:0] st, logic [7:0] val, bit lst);
    result_t r;
    r.byte_val = (st == ST_OK) ? val : 8'h00;
    r.status = st;
    r.last = lst || (st != ST_OK);
    pending_bytes.push_back(r);
    mode = (st != ST_OK && !lst) ? MODE_DROP : MODE_IDLE;
    digit_cnt = '0;
    acc = '0;
  endfunction

  // Emit a decoded byte, flagged if it hits the ban list
  function void put_byte(logic [7:0] val, bit lst);
    int n;
    bit hit;
    n = (ban_cnt > BAN_ENTRIES_DEF) ? BAN_ENTRIES_DEF : ban_cnt;
    hit = 1'b0;
    for (int i = 0; i < n; i++)
      if (ban_list[8*i +: 8] == val) hit = 1'b1;
    close_word((ban_en && hit) ? ST_BANNED : ST_OK, val, lst);
  endfunction

  // Escape still open: a string end here is an invalid escape
  function void need_more(bit lst);
    if (lst) close_word(ST_INVALID, 8'h00, 1'b1);
  endfunction

  // Advance the decoder by one accepted character
  function void take_char(logic [7:0] c, bit lst);
    logic [7:0] lc;
    logic [7:0] uc;
    logic [3:0] nib;
    bit         is_hex;
    lc = (c >= CH_UC_A && c <= CH_UC_Z) ? c + CASE_GAP : c;
    uc = (c >= CH_LC_A && c <= CH_LC_Z) ? c - CASE_GAP : c;
    case (mode)
      MODE_IDLE: begin
        if (c == CH_BSLASH) begin
          mode = MODE_ESC;
          need_more(lst);
        end else begin
          put_byte(c, lst);
        end
      end
      MODE_ESC: begin
        case (lc)
          CH_BSLASH: put_byte(8'h5C, lst);
          CH_LC_A:   put_byte(8'h07, lst);
          CH_LC_B:   put_byte(8'h08, lst);
          CH_LC_T:   put_byte(8'h09, lst);
          CH_LC_N:   put_byte(8'h0A, lst);
          CH_LC_V:   put_byte(8'h0B, lst);
          CH_LC_F:   put_byte(8'h0C, lst);
          CH_LC_R:   put_byte(8'h0D, lst);
          CH_LC_E:   put_byte(8'h1B, lst);
          CH_CARET: begin
            mode = MODE_CARET;
            need_more(lst);
          end
          CH_LC_D: begin
            mode = MODE_DEC;
            digit_cnt = '0;
            acc = '0;
            need_more(lst);
          end
          CH_LC_X: begin
            mode = MODE_HEX;
            digit_cnt = '0;
            acc = '0;
            need_more(lst);
          end
          default: begin
            if (c >= CH_ZERO && c <= CH_SEVEN) begin
              mode = MODE_OCT;
              digit_cnt = 2'd1;
              acc = {2'b00, c - CH_ZERO};
              need_more(lst);
            end else begin
              close_word(ST_INVALID, 8'h00, lst);
            end
          end
        endcase
      end
      MODE_CARET: begin
        if (uc < CH_QUEST || uc > CH_UNDER) close_word(ST_INVALID, 8'h00, lst);
        else put_byte((uc - CTRL_BASE) & CTRL_MASK, lst);
      end
      MODE_DEC: begin
        if (c < CH_ZERO || c > CH_NINE) begin
          close_word(ST_INVALID, 8'h00, lst);
        end else begin
          acc = acc * 10'd10 + {2'b00, c - CH_ZERO};
          digit_cnt++;
          if (digit_cnt == 2'd3) begin
            if (acc > BYTE_MAX) close_word(ST_INVALID, 8'h00, lst);
            else put_byte(acc[7:0], lst);
          end else begin
            need_more(lst);
          end
        end
      end
      MODE_HEX: begin
        is_hex = 1'b1;
        nib = '0;
        if (c >= CH_ZERO && c <= CH_NINE) nib = 4'(c - CH_ZERO);
        else if (c >= CH_LC_A && c <= CH_LC_F) nib = 4'(c - CH_LC_A + 8'd10);
        else if (c >= CH_UC_A && c <= CH_UC_F) nib = 4'(c - CH_UC_A + 8'd10);
        else is_hex = 1'b0;
        if (!is_hex) begin
          close_word(ST_INVALID, 8'h00, lst);
        end else begin
          acc = acc * 10'd16 + {6'b0, nib};
          digit_cnt++;
          if (digit_cnt == 2'd2) put_byte(acc[7:0], lst);
          else need_more(lst);
        end
      end
      MODE_OCT: begin
        if (c < CH_ZERO || c > CH_SEVEN) begin
          close_word(ST_INVALID, 8'h00, lst);
        end else begin
          acc = acc * 10'd8 + {2'b00, c - CH_ZERO};
          digit_cnt++;
          if (digit_cnt == 2'd3) begin
            if (acc > BYTE_MAX) close_word(ST_INVALID, 8'h00, lst);
            else put_byte(acc[7:0], lst);
          end else begin
            need_more(lst);
          end
        end
      end
      default: begin
        // Drop the rest of a failed string
        if (lst) begin
          mode = MODE_IDLE;
          digit_cnt = '0;
          acc = '0;
        end
      end
    endcase
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("mismatch: %s", msg);
  endtask

  // Compare one output word with the oldest pending byte
  task match_byte(logic [7:0] b, logic [1:0] st, logic lst);
    result_t want;
    if (pending_bytes.size() == 0) begin
      report($sformatf("unexpected word byte=%02h status=%0d last=%0b", b, st, lst));
      return;
    end
    want = pending_bytes.pop_front();
    if (b !== want.byte_val)
      report($sformatf("byte %02h, want %02h", b, want.byte_val));
    if (st !== want.status)
      report($sformatf("status %0d, want %0d", st, want.status));
    if (lst !== want.last)
      report($sformatf("last %0b, want %0b", lst, want.last));
  endtask
endclass

module tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_CHARS  = 1850;
  localparam int PHASE_CHARS   = 160;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  decode_scoreboard sb = new();

  logic [7:0] text_q[$];
  bit         tx_idle_on;
  bit         rx_stall_on;
  int         chars_sent;
  int         cycle_count;
  int         phase;
  int         phase_start;

  escape_sequence_decoder_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Observe every handshake on the pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.match_byte(m_tdata, m_tuser, m_tlast);
      if (s_tvalid && s_tready) sb.take_char(s_tdata, s_tlast);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
    end
  end

  // Mostly short gaps, a few long ones
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stall the output side at random
  initial begin
    int hold;
    hold = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (rx_stall_on && $urandom_range(0, 4) == 0) hold = pick_gap();
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input bit lst);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= lst;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  // Send the queued text as one string, last flag on its final word
  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++)
      send_char(text_q[i], i == text_q.size() - 1);
  endtask

  // Hold the input until all pending bytes are out and the pipe is quiet
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input bit en, input logic [63:0] list,
                              input logic [3:0] cnt);
    logic [1:0]  idx[3];
    logic [63:0] val[3];
    idx[0] = CFG_BAN_ENABLE;
    val[0] = {63'b0, en};
    idx[1] = CFG_BAN_BYTES;
    val[1] = list;
    idx[2] = CFG_BAN_COUNT;
    val[2] = {60'b0, cnt};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Ban list biased toward bytes the decoder often produces
  function logic [63:0] pick_ban_list();
    logic [7:0]  common[8];
    logic [63:0] list;
    common = '{8'h00, 8'hFF, 8'h0A, 8'h5C, 8'h1B, 8'h7F, 8'h41, 8'h61};
    list = {$urandom, $urandom};
    for (int i = 0; i < 8; i++)
      if ($urandom_range(0, 1)) list[8*i +: 8] = common[3'($urandom_range(0, 7))];
    return list;
  endfunction

  // Append one plain character or escape; wild allows out-of-range content
  task automatic add_token(input bit wild);
    logic [7:0] letters[9];
    logic [7:0] c;
    int         v;
    letters = '{CH_BSLASH, CH_LC_A, CH_LC_B, CH_LC_T, CH_LC_N,
                CH_LC_V, CH_LC_F, CH_LC_R, CH_LC_E};
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_BSLASH) c = CH_UNDER;
        text_q.push_back(c);
      end
      3: begin
        c = letters[$urandom_range(0, 8)];
        if (c != CH_BSLASH && $urandom_range(0, 1)) c = c - CASE_GAP;
        text_q.push_back(CH_BSLASH);
        text_q.push_back(c);
      end
      4: begin
        c = $urandom_range(0, 1) ? 8'($urandom_range(CH_QUEST, CH_UNDER))
                                 : 8'($urandom_range(CH_LC_A, CH_LC_Z));
        if (wild) c = 8'($urandom_range(0, 255));
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_CARET);
        text_q.push_back(c);
      end
      5: begin
        v = wild ? $urandom_range(0, 999) : $urandom_range(0, 255);
        text_q.push_back(CH_BSLASH);
        text_q.push_back($urandom_range(0, 1) ? CH_LC_D : CH_LC_D - CASE_GAP);
        text_q.push_back(8'(CH_ZERO + v / 100));
        text_q.push_back(8'(CH_ZERO + (v / 10) % 10));
        text_q.push_back(8'(CH_ZERO + v % 10));
      end
      6: begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back($urandom_range(0, 1) ? CH_LC_X : CH_LC_X - CASE_GAP);
        repeat (2) begin
          v = $urandom_range(0, 15);
          if (v < 10) c = 8'(CH_ZERO + v);
          else c = 8'(($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + v - 10);
          text_q.push_back(c);
        end
      end
      7: begin
        v = wild ? $urandom_range(0, 511) : $urandom_range(0, 255);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(8'(CH_ZERO + v / 64));
        text_q.push_back(8'(CH_ZERO + (v / 8) % 8));
        text_q.push_back(8'(CH_ZERO + v % 8));
      end
      8: begin
        // Backslash followed by anything at all
        text_q.push_back(CH_BSLASH);
        text_q.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_BSLASH) c = CH_QUEST;
        text_q.push_back(c);
      end
    endcase
  endtask

  // Build one random string, now and then corrupted
  task automatic make_text();
    int  pos;
    bit  broken;
    text_q.delete();
    broken = ($urandom_range(0, 6) == 0);
    repeat ($urandom_range(1, 6)) add_token(broken);
    if (broken) begin
      case ($urandom_range(0, 2))
        0: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        1: begin
          pos = $urandom_range(1, text_q.size());
          while (text_q.size() > pos) void'(text_q.pop_back());
        end
        default: text_q.push_back(CH_BSLASH);
      endcase
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BAN_ENABLE;
    cfg_data <= '0;
    tx_idle_on = 1'b1;
    rx_stall_on = 1'b1;
    chars_sent = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed strings; ban list holds only 'A'
    program_regs(1'b1, 64'h41, 4'd1);
    // NUL, escaped backslash, high byte
    text_q = '{8'h00, CH_BSLASH, CH_BSLASH, 8'hFF};
    send_text();
    // Control code from '?', then hex FF in mixed case
    text_q = '{CH_BSLASH, CH_CARET, CH_QUEST, CH_BSLASH, CH_LC_X, CH_UC_F, CH_LC_F};
    send_text();
    // Largest decimal value
    text_q = '{CH_BSLASH, CH_LC_D, 8'h32, 8'h35, 8'h35};
    send_text();
    // Octal value past 0377
    text_q = '{CH_BSLASH, 8'h34, 8'h30, 8'h30};
    send_text();
    // Unknown escape letter, rest of string dropped
    text_q = '{CH_BSLASH, 8'h71, 8'h7A};
    send_text();
    // Bad hex digit
    text_q = '{CH_BSLASH, CH_LC_X, 8'h67};
    send_text();
    // String ends inside an escape
    text_q = '{CH_BSLASH};
    send_text();
    // Banned plain byte
    text_q = '{CH_UC_A};
    send_text();
    wait_drained();

    // Random phases, each under its own ban setting
    phase = 0;
    while (chars_sent < RANDOM_CHARS + 28) begin
      case (phase)
        0: program_regs(1'b0, {$urandom, $urandom}, 4'($urandom_range(0, 15)));
        1: program_regs(1'b1, '1, 4'd8);
        2: program_regs(1'b1, '0, 4'd15);
        3: program_regs(1'b1, pick_ban_list(), 4'd0);
        default: program_regs($urandom_range(0, 3) != 0, pick_ban_list(),
                              4'($urandom_range(0, 15)));
      endcase
      tx_idle_on = (phase % 4 != 2);
      rx_stall_on = (phase % 4 != 2);
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        make_text();
        send_text();
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
      wait_drained();
      phase++;
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/esd_pkg.sv
rtl/core/esd_ban_match.sv
rtl/core/esd_decode.sv
rtl/core/esd_out_buf.sv
rtl/core/escape_sequence_decoder_unit.sv
bench/tb.sv
